// ===== rtl/core/imh_pkg.sv =====
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types, constants and helpers of the indexed max-heap unit.
// ----------------------------------------------------------------------------
`default_nettype none

package imh_pkg;

	localparam int CAPACITY = 1024;
	localparam int ID_SPACE = 1024;
	localparam int ID_W     = 10;
	localparam int KEY_W    = 16;
	localparam int SLOT_W   = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);

	typedef enum logic [1:0] {
		OP_CLEAR     = 2'd0,
		OP_INSERT    = 2'd1,
		OP_EXTRACT   = 2'd2,
		OP_INCREMENT = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_EMPTY       = 3'd1,
		ST_FULL        = 3'd2,
		ST_PRESENT     = 3'd3,
		ST_NOT_PRESENT = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		C_NOP,
		C_LATCH,
		C_CLEAR,
		C_RD_ID,
		C_INS_CHK,
		C_INC_CHK,
		C_UP_RDP,
		C_UP_RDK,
		C_UP_MOVE,
		C_PLACE,
		C_EX_RD0,
		C_EX_RDK,
		C_EX_TOP,
		C_EX_LK,
		C_DN_RDL,
		C_DN_RDR,
		C_DN_RDRK,
		C_DN_CMP
	} cmd_t;

	typedef struct packed {
		logic [1:0]      operation;
		logic [ID_W-1:0] item_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]   result_id;
		logic [KEY_W-1:0]  result_key;
		logic [2:0]        status;
		logic [SLOT_W-1:0] heap_count;
	} rsp_t;

	typedef struct packed {
		logic [1:0] op;
		logic       empty;
		logic       present;
		logic       full;
		logic       pos_gt1;
		logic       up_move;
		logic       has_child;
		logic       dn_move;
		logic       clr_last;
	} flags_t;

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W:0] pos);
		logic [SLOT_W:0] t;
		t = pos - (SLOT_W + 1)'(1);
		return t[ADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/indexed_max_heap_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_max_heap_unit
// Indexed binary max-heap of ids ordered by a saturating per-id key.
// ----------------------------------------------------------------------------
// A command beat is taken at a rising edge where start is high and busy is
// low; request carries the operation and the id. Exactly one result beat
// follows, shown on response for one cycle while done is high. The receiver
// cannot stall, so it must take the beat in that cycle.
// Busy stays high from acceptance until the result cycle, and a new command
// may be given in the cycle done is high.
// Insert and increment sift the entry up toward the root, one level per
// step; extract moves the last entry to the root and sifts it down; clear
// sweeps every key and position entry to zero. A rejected insert or
// increment and an extract from an empty heap end without a sift.
// The sift loops are bounded by the single read port of each memory, with
// one registered read of each memory per state.
// After reset the block is busy while it sweeps the key and position
// memories to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_max_heap_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire imh_pkg::req_t request,
	output logic               busy,
	output logic               done,
	output imh_pkg::rsp_t      response
);

	imh_pkg::cmd_t   cmd;
	imh_pkg::flags_t flags;

	imh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	imh_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.request  (request),
		.flags    (flags),
		.response (response)
	);

endmodule

`default_nettype wire

// ===== rtl/core/imh_dp.sv =====
// ----------------------------------------------------------------------------
// imh_dp
// Datapath of the indexed max-heap: slot, position and key memories, the
// moving entry, the sift position and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module imh_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire imh_pkg::cmd_t cmd,
	input  wire imh_pkg::req_t request,
	output imh_pkg::flags_t    flags,
	output imh_pkg::rsp_t      response
);

	localparam int AW = imh_pkg::ADDR_W;
	localparam int IW = imh_pkg::ID_W;
	localparam int KW = imh_pkg::KEY_W;
	localparam int SW = imh_pkg::SLOT_W;

	logic [IW-1:0] hs_mem  [imh_pkg::CAPACITY];
	logic [SW-1:0] sid_mem [imh_pkg::ID_SPACE];
	logic [KW-1:0] key_mem [imh_pkg::ID_SPACE];

	logic          hs_we, sid_we, key_we;
	logic [AW-1:0] hs_wa, hs_ra;
	logic [IW-1:0] hs_wd, sid_wa, sid_ra, key_wa, key_ra;
	logic [SW-1:0] sid_wd;
	logic [KW-1:0] key_wd;
	logic [IW-1:0] hs_rd_q;
	logic [SW-1:0] sid_rd_q;
	logic [KW-1:0] key_rd_q;

	logic [1:0]    op_q;
	logic [IW-1:0] id_q, x_q, par_q, top_q, l_q, r_q;
	logic [KW-1:0] kx_q, lkey_q;
	logic [SW-1:0] cnt_q, pos_q;
	logic [IW-1:0] clr_q;
	logic [IW-1:0] rid_q;
	logic [KW-1:0] rkey_q;
	logic [2:0]    status_q;

	logic [SW:0]   pos2, cnt12;
	logic          has_right, take_right;
	logic [KW-1:0] ckey, key_inc;
	logic [IW-1:0] c_id;
	logic [SW-1:0] cpos;

	assign pos2       = {pos_q, 1'b0};
	assign cnt12      = {1'b0, cnt_q};
	assign has_right  = pos2 < cnt12;
	assign take_right = has_right && (key_rd_q > lkey_q);
	assign ckey       = take_right ? key_rd_q : lkey_q;
	assign c_id       = take_right ? r_q : l_q;
	assign cpos       = take_right ? (pos2[SW-1:0] | SW'(1)) : pos2[SW-1:0];
	assign key_inc    = (key_rd_q == {KW{1'b1}}) ? key_rd_q : key_rd_q + KW'(1);

	assign flags.op        = op_q;
	assign flags.empty     = cnt_q == '0;
	assign flags.present   = sid_rd_q != '0;
	assign flags.full      = cnt_q == SW'(imh_pkg::CAPACITY);
	assign flags.pos_gt1   = pos_q > SW'(1);
	assign flags.up_move   = key_rd_q < kx_q;
	assign flags.has_child = pos2 <= cnt12;
	assign flags.dn_move   = kx_q < ckey;
	assign flags.clr_last  = clr_q == {IW{1'b1}};

	assign response.result_id  = rid_q;
	assign response.result_key = rkey_q;
	assign response.status     = status_q;
	assign response.heap_count = cnt_q;

	always_comb begin
		hs_we  = 1'b0;
		sid_we = 1'b0;
		key_we = 1'b0;
		hs_wa  = imh_pkg::slot_addr({1'b0, pos_q});
		hs_wd  = x_q;
		hs_ra  = imh_pkg::slot_addr({1'b0, pos_q});
		sid_wa = x_q;
		sid_wd = pos_q;
		sid_ra = id_q;
		key_wa = id_q;
		key_wd = key_inc;
		key_ra = id_q;
		unique case (cmd)
			imh_pkg::C_CLEAR: begin
				sid_we = 1'b1;
				key_we = 1'b1;
				sid_wa = clr_q;
				key_wa = clr_q;
				sid_wd = '0;
				key_wd = '0;
			end
			imh_pkg::C_INC_CHK: begin
				key_we = sid_rd_q != '0;
			end
			imh_pkg::C_UP_RDP: begin
				hs_ra = imh_pkg::slot_addr({2'b00, pos_q[SW-1:1]});
			end
			imh_pkg::C_UP_RDK: begin
				key_ra = hs_rd_q;
			end
			imh_pkg::C_UP_MOVE: begin
				hs_we  = key_rd_q < kx_q;
				sid_we = key_rd_q < kx_q;
				hs_wd  = par_q;
				sid_wa = par_q;
			end
			imh_pkg::C_PLACE: begin
				hs_we  = 1'b1;
				sid_we = 1'b1;
			end
			imh_pkg::C_EX_RD0: begin
				hs_ra = '0;
			end
			imh_pkg::C_EX_RDK: begin
				key_ra = hs_rd_q;
				hs_ra  = imh_pkg::slot_addr({1'b0, cnt_q});
			end
			imh_pkg::C_EX_TOP: begin
				sid_we = 1'b1;
				sid_wa = top_q;
				sid_wd = '0;
				key_ra = hs_rd_q;
			end
			imh_pkg::C_DN_RDL: begin
				hs_ra = imh_pkg::slot_addr(pos2);
			end
			imh_pkg::C_DN_RDR: begin
				key_ra = hs_rd_q;
				hs_ra  = imh_pkg::slot_addr(pos2 | (SW + 1)'(1));
			end
			imh_pkg::C_DN_RDRK: begin
				key_ra = hs_rd_q;
			end
			imh_pkg::C_DN_CMP: begin
				hs_we  = kx_q < ckey;
				sid_we = kx_q < ckey;
				hs_wd  = c_id;
				sid_wa = c_id;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (hs_we) begin
			hs_mem[hs_wa] <= hs_wd;
		end
		hs_rd_q <= hs_mem[hs_ra];
	end

	always_ff @(posedge clk) begin
		if (sid_we) begin
			sid_mem[sid_wa] <= sid_wd;
		end
		sid_rd_q <= sid_mem[sid_ra];
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_wa] <= key_wd;
		end
		key_rd_q <= key_mem[key_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			clr_q <= '0;
		end else begin
			unique case (cmd)
				imh_pkg::C_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					cnt_q <= '0;
				end
				imh_pkg::C_INS_CHK: begin
					if (sid_rd_q == '0 && cnt_q != SW'(imh_pkg::CAPACITY)) begin
						cnt_q <= cnt_q + SW'(1);
					end
				end
				imh_pkg::C_EX_TOP: begin
					cnt_q <= cnt_q - SW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			imh_pkg::C_LATCH: begin
				op_q     <= request.operation;
				id_q     <= request.item_id;
				rid_q    <= request.item_id;
				rkey_q   <= '0;
				status_q <= imh_pkg::ST_OK;
			end
			imh_pkg::C_INS_CHK: begin
				rkey_q <= key_rd_q;
				kx_q   <= key_rd_q;
				x_q    <= id_q;
				pos_q  <= cnt_q + SW'(1);
				if (sid_rd_q != '0) begin
					status_q <= imh_pkg::ST_PRESENT;
				end else if (cnt_q == SW'(imh_pkg::CAPACITY)) begin
					status_q <= imh_pkg::ST_FULL;
				end
			end
			imh_pkg::C_INC_CHK: begin
				if (sid_rd_q == '0) begin
					status_q <= imh_pkg::ST_NOT_PRESENT;
					rkey_q   <= key_rd_q;
				end else begin
					rkey_q <= key_inc;
					kx_q   <= key_inc;
					x_q    <= id_q;
					pos_q  <= sid_rd_q;
				end
			end
			imh_pkg::C_UP_RDK: begin
				par_q <= hs_rd_q;
			end
			imh_pkg::C_UP_MOVE: begin
				if (key_rd_q < kx_q) begin
					pos_q <= {1'b0, pos_q[SW-1:1]};
				end
			end
			imh_pkg::C_EX_RD0: begin
				if (cnt_q == '0) begin
					status_q <= imh_pkg::ST_EMPTY;
					rid_q    <= '0;
				end
			end
			imh_pkg::C_EX_RDK: begin
				top_q <= hs_rd_q;
			end
			imh_pkg::C_EX_TOP: begin
				rid_q  <= top_q;
				rkey_q <= key_rd_q;
				x_q    <= hs_rd_q;
				pos_q  <= SW'(1);
			end
			imh_pkg::C_EX_LK: begin
				kx_q <= key_rd_q;
			end
			imh_pkg::C_DN_RDR: begin
				l_q <= hs_rd_q;
			end
			imh_pkg::C_DN_RDRK: begin
				lkey_q <= key_rd_q;
				r_q    <= hs_rd_q;
			end
			imh_pkg::C_DN_CMP: begin
				if (kx_q < ckey) begin
					pos_q <= cpos;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/imh_ctrl.sv =====
// ----------------------------------------------------------------------------
// imh_ctrl
// Sequencer of the indexed max-heap: steps each operation through memory
// reads, compares and moves, and runs the key and position clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module imh_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire imh_pkg::flags_t flags,
	output imh_pkg::cmd_t        cmd,
	output logic                 busy,
	output logic                 done
);

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_DISPATCH,
		S_CLR,
		S_RD_ID,
		S_INS_CHK,
		S_INC_CHK,
		S_UP_CHK,
		S_UP_RDP,
		S_UP_RDK,
		S_UP_CMP,
		S_PLACE,
		S_EX_RD0,
		S_EX_RDK,
		S_EX_TOP,
		S_EX_LK,
		S_DN_CHK,
		S_DN_RDL,
		S_DN_RDR,
		S_DN_RDRK,
		S_DN_CMP
	} state_t;

	state_t state_q;

	assign busy = state_q != S_IDLE;

	always_comb begin
		unique case (state_q)
			S_INIT:    cmd = imh_pkg::C_CLEAR;
			S_IDLE:    cmd = start ? imh_pkg::C_LATCH : imh_pkg::C_NOP;
			S_CLR:     cmd = imh_pkg::C_CLEAR;
			S_RD_ID:   cmd = imh_pkg::C_RD_ID;
			S_INS_CHK: cmd = imh_pkg::C_INS_CHK;
			S_INC_CHK: cmd = imh_pkg::C_INC_CHK;
			S_UP_RDP:  cmd = imh_pkg::C_UP_RDP;
			S_UP_RDK:  cmd = imh_pkg::C_UP_RDK;
			S_UP_CMP:  cmd = imh_pkg::C_UP_MOVE;
			S_PLACE:   cmd = imh_pkg::C_PLACE;
			S_EX_RD0:  cmd = imh_pkg::C_EX_RD0;
			S_EX_RDK:  cmd = imh_pkg::C_EX_RDK;
			S_EX_TOP:  cmd = imh_pkg::C_EX_TOP;
			S_EX_LK:   cmd = imh_pkg::C_EX_LK;
			S_DN_RDL:  cmd = imh_pkg::C_DN_RDL;
			S_DN_RDR:  cmd = imh_pkg::C_DN_RDR;
			S_DN_RDRK: cmd = imh_pkg::C_DN_RDRK;
			S_DN_CMP:  cmd = imh_pkg::C_DN_CMP;
			default:   cmd = imh_pkg::C_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					if (flags.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					unique case (flags.op)
						imh_pkg::OP_CLEAR:   state_q <= S_CLR;
						imh_pkg::OP_EXTRACT: state_q <= S_EX_RD0;
						default:             state_q <= S_RD_ID;
					endcase
				end
				S_CLR: begin
					if (flags.clr_last) begin
						state_q <= S_IDLE;
						done    <= 1'b1;
					end
				end
				S_RD_ID: begin
					state_q <= (flags.op == imh_pkg::OP_INSERT) ? S_INS_CHK : S_INC_CHK;
				end
				S_INS_CHK: begin
					if (flags.present || flags.full) begin
						state_q <= S_IDLE;
						done    <= 1'b1;
					end else begin
						state_q <= S_UP_CHK;
					end
				end
				S_INC_CHK: begin
					if (!flags.present) begin
						state_q <= S_IDLE;
						done    <= 1'b1;
					end else begin
						state_q <= S_UP_CHK;
					end
				end
				S_UP_CHK: begin
					state_q <= flags.pos_gt1 ? S_UP_RDP : S_PLACE;
				end
				S_UP_RDP: begin
					state_q <= S_UP_RDK;
				end
				S_UP_RDK: begin
					state_q <= S_UP_CMP;
				end
				S_UP_CMP: begin
					state_q <= flags.up_move ? S_UP_CHK : S_PLACE;
				end
				S_PLACE: begin
					state_q <= S_IDLE;
					done    <= 1'b1;
				end
				S_EX_RD0: begin
					if (flags.empty) begin
						state_q <= S_IDLE;
						done    <= 1'b1;
					end else begin
						state_q <= S_EX_RDK;
					end
				end
				S_EX_RDK: begin
					state_q <= S_EX_TOP;
				end
				S_EX_TOP: begin
					state_q <= S_EX_LK;
				end
				S_EX_LK: begin
					if (flags.empty) begin
						state_q <= S_IDLE;
						done    <= 1'b1;
					end else begin
						state_q <= S_DN_CHK;
					end
				end
				S_DN_CHK: begin
					state_q <= flags.has_child ? S_DN_RDL : S_PLACE;
				end
				S_DN_RDL: begin
					state_q <= S_DN_RDR;
				end
				S_DN_RDR: begin
					state_q <= S_DN_RDRK;
				end
				S_DN_RDRK: begin
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					state_q <= flags.dn_move ? S_DN_CHK : S_PLACE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
